FILE: sv/pwmpm_pkg.sv
// pwmpm_pkg: shared types and constants of the pwm period, prescaler and duty manager
// depends on nothing; imported by every module of the block
package pwmpm_pkg;

  localparam int TOP_WIDTH = 16;
  localparam int DUTY_FRAC = 16;
  localparam int VAL_WIDTH = 32;
  localparam int MARGIN_WIDTH = 15;
  localparam int SEL_WIDTH = 3;

  // command queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // reset values of the configuration registers
  localparam logic [TOP_WIDTH-1:0]    TOP_LIMIT_RST   = 16'd65535;
  localparam logic [TOP_WIDTH-1:0]    TOP_FLOOR_RST   = 16'd3;
  localparam logic [MARGIN_WIDTH-1:0] DUTY_MARGIN_RST = 15'd1;

  // prescaler codes
  localparam logic [SEL_WIDTH-1:0] SEL_DIV1    = 3'd1;
  localparam logic [SEL_WIDTH-1:0] SEL_DIV8    = 3'd2;
  localparam logic [SEL_WIDTH-1:0] SEL_DIV64   = 3'd3;
  localparam logic [SEL_WIDTH-1:0] SEL_DIV256  = 3'd4;
  localparam logic [SEL_WIDTH-1:0] SEL_DIV1024 = 3'd5;

  typedef enum logic [2:0] {
    KIND_PERIOD_NOW = 3'd0,
    KIND_PERIOD_OVF = 3'd1,
    KIND_PERIOD_UP  = 3'd2,
    KIND_PERIOD_DN  = 3'd3,
    KIND_DUTY_SET   = 3'd4,
    KIND_DUTY_UP    = 3'd5,
    KIND_DUTY_DN    = 3'd6,
    KIND_OVERFLOW   = 3'd7
  } kind_t;

  typedef struct packed {
    logic [TOP_WIDTH-1:0]    top_limit;
    logic [TOP_WIDTH-1:0]    top_floor;
    logic [MARGIN_WIDTH-1:0] duty_margin;
  } cfg_t;

  // classified command as held in the queue
  typedef struct packed {
    kind_t                kind;
    logic                 channel;
    logic [VAL_WIDTH-1:0] value;
    logic [TOP_WIDTH-1:0] map_top;
    logic [SEL_WIDTH-1:0] map_sel;
  } cmd_t;

endpackage

FILE: sv/pwmpm_cfg.sv
// pwmpm_cfg: apb register file holding top_limit, top_floor and duty_margin
// depends on pwmpm_pkg
module pwmpm_cfg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output pwmpm_pkg::cfg_t   cfg
);
  import pwmpm_pkg::*;

  localparam logic [1:0] REG_TOP_LIMIT   = 2'd0;
  localparam logic [1:0] REG_TOP_FLOOR   = 2'd1;
  localparam logic [1:0] REG_DUTY_MARGIN = 2'd2;

  logic [TOP_WIDTH-1:0]    top_limit_r;
  logic [TOP_WIDTH-1:0]    top_floor_r;
  logic [MARGIN_WIDTH-1:0] duty_margin_r;
  logic                    wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_limit_r   <= TOP_LIMIT_RST;
      top_floor_r   <= TOP_FLOOR_RST;
      duty_margin_r <= DUTY_MARGIN_RST;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_TOP_LIMIT:   top_limit_r   <= pwdata[TOP_WIDTH-1:0];
        REG_TOP_FLOOR:   top_floor_r   <= pwdata[TOP_WIDTH-1:0];
        REG_DUTY_MARGIN: duty_margin_r <= pwdata[MARGIN_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_TOP_LIMIT:   prdata = 32'(top_limit_r);
      REG_TOP_FLOOR:   prdata = 32'(top_floor_r);
      REG_DUTY_MARGIN: prdata = 32'(duty_margin_r);
      default:         prdata = '0;
    endcase
  end

  assign cfg.top_limit   = top_limit_r;
  assign cfg.top_floor   = top_floor_r;
  assign cfg.duty_margin = duty_margin_r;

endmodule

FILE: sv/pwmpm_front.sv
// pwmpm_front: input beat acceptance, command decode and period to prescaler mapping
// depends on pwmpm_pkg
module pwmpm_front (
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [3:0]           in_tuser,   // [2:0] kind, [3] channel
  input  logic [31:0]          in_tdata,   // [31:0] value
  input  pwmpm_pkg::cfg_t      cfg,
  input  logic                 q_full,
  output logic                 q_push,
  output pwmpm_pkg::cmd_t      q_cmd
);
  import pwmpm_pkg::*;

  logic [VAL_WIDTH-1:0] lim_ext;
  logic [VAL_WIDTH-1:0] c_sh3, c_sh6, c_sh8, c_sh10;
  logic [VAL_WIDTH-1:0] c_sel;
  logic [SEL_WIDTH-1:0] sel;

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && in_tready;

  assign lim_ext = VAL_WIDTH'(cfg.top_limit);
  assign c_sh3   = in_tdata >> 3;
  assign c_sh6   = in_tdata >> 6;
  assign c_sh8   = in_tdata >> 8;
  assign c_sh10  = in_tdata >> 10;

  // smallest prescaler whose scaled count fits within top_limit; else /1024 with the count clamped to top_limit
  always_comb begin
    if (in_tdata <= lim_ext) begin
      c_sel = in_tdata;
      sel   = SEL_DIV1;
    end else if (c_sh3 <= lim_ext) begin
      c_sel = c_sh3;
      sel   = SEL_DIV8;
    end else if (c_sh6 <= lim_ext) begin
      c_sel = c_sh6;
      sel   = SEL_DIV64;
    end else if (c_sh8 <= lim_ext) begin
      c_sel = c_sh8;
      sel   = SEL_DIV256;
    end else begin
      c_sel = (c_sh10 > lim_ext) ? lim_ext : c_sh10;
      sel   = SEL_DIV1024;
    end
  end

  assign q_cmd.kind    = kind_t'(in_tuser[2:0]);
  assign q_cmd.channel = in_tuser[3];
  assign q_cmd.value   = in_tdata;
  assign q_cmd.map_top = c_sel[TOP_WIDTH-1:0];
  assign q_cmd.map_sel = sel;

endmodule

FILE: sv/pwmpm_queue.sv
// pwmpm_queue: short command fifo between front and back
// depends on pwmpm_pkg
module pwmpm_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  pwmpm_pkg::cmd_t  push_cmd,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output pwmpm_pkg::cmd_t  head
);
  import pwmpm_pkg::*;

  cmd_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  assign full  = (count_r == QCNT_W'(QDEPTH));
  assign valid = (count_r != '0);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full && !pop))
    else $error("command queue written while full");

  a_no_underrun: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> valid)
    else $error("command queue read while empty");

endmodule

FILE: sv/pwmpm_back.sv
// pwmpm_back: executes queued commands on the timer state, which doubles as the result register
// depends on pwmpm_pkg
module pwmpm_back (
  input  logic             clk,
  input  logic             rst_n,
  input  pwmpm_pkg::cfg_t  cfg,
  input  logic             q_valid,
  input  pwmpm_pkg::cmd_t  q_cmd,
  output logic             q_pop,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [55:0]      out_tdata
);
  import pwmpm_pkg::*;

  logic [TOP_WIDTH-1:0] wanted_top_r, wanted_top_nxt;
  logic [SEL_WIDTH-1:0] wanted_sel_r, wanted_sel_nxt;
  logic [TOP_WIDTH-1:0] cur_top_r, cur_top_nxt;
  logic [SEL_WIDTH-1:0] cur_sel_r, cur_sel_nxt;
  logic [TOP_WIDTH-1:0] duty_a_r, duty_a_nxt;
  logic [TOP_WIDTH-1:0] duty_b_r, duty_b_nxt;
  logic                 pending_r, pending_nxt;
  logic                 out_valid_r, out_valid_nxt;

  logic [TOP_WIDTH-1:0]             margin;
  logic [TOP_WIDTH-1:0]             hi_cur;
  logic [TOP_WIDTH-1:0]             apply_top;
  logic [TOP_WIDTH-1:0]             apply_hi;
  logic [TOP_WIDTH-1:0]             clamp_a, clamp_b;
  logic [TOP_WIDTH-1:0]             duty_cur;
  logic [TOP_WIDTH+VAL_WIDTH-1:0]   prod;
  logic [VAL_WIDTH-1:0]             prod_hi;
  logic [TOP_WIDTH-1:0]             d_set, duty_new;
  logic [TOP_WIDTH:0]               n_up;
  logic [TOP_WIDTH-1:0]             up_top, dn_top, dn_floor;
  logic [SEL_WIDTH-1:0]             up_sel, dn_sel;

  function automatic logic [TOP_WIDTH-1:0] upper_of(
    input logic [TOP_WIDTH-1:0] top, input logic [TOP_WIDTH-1:0] m);
    return (top >= m) ? top - m : '0;
  endfunction

  // lower bound first, upper bound last
  function automatic logic [TOP_WIDTH-1:0] clamp_of(
    input logic [TOP_WIDTH-1:0] d, input logic [TOP_WIDTH-1:0] hi,
    input logic [TOP_WIDTH-1:0] m);
    logic [TOP_WIDTH-1:0] t;
    t = (d < m) ? m : d;
    return (t > hi) ? hi : t;
  endfunction

  assign margin   = TOP_WIDTH'(cfg.duty_margin);
  assign hi_cur   = upper_of(cur_top_r, margin);
  assign duty_cur = q_cmd.channel ? duty_b_r : duty_a_r;

  // re-clamp of both duties against the top being applied
  assign apply_top = (q_cmd.kind == KIND_PERIOD_NOW) ? q_cmd.map_top : wanted_top_r;
  assign apply_hi  = upper_of(apply_top, margin);
  assign clamp_a   = clamp_of(duty_a_r, apply_hi, margin);
  assign clamp_b   = clamp_of(duty_b_r, apply_hi, margin);

  // proportional duty
  assign prod    = (TOP_WIDTH+VAL_WIDTH)'(cur_top_r) * (TOP_WIDTH+VAL_WIDTH)'(q_cmd.value);
  assign prod_hi = prod[TOP_WIDTH+VAL_WIDTH-1:DUTY_FRAC];
  assign d_set   = (prod_hi > VAL_WIDTH'(hi_cur)) ? hi_cur : prod_hi[TOP_WIDTH-1:0];

  // period step up, crossing into the next prescaler on overflow of top_limit; at /1024 it saturates at top_limit
  assign n_up = {1'b0, wanted_top_r} + 1'b1;
  always_comb begin
    up_top = n_up[TOP_WIDTH-1:0];
    up_sel = wanted_sel_r;
    if (n_up > {1'b0, cfg.top_limit}) begin
      case (wanted_sel_r)
        SEL_DIV1: begin
          up_top = TOP_WIDTH'(n_up >> 3);
          up_sel = SEL_DIV8;
        end
        SEL_DIV8: begin
          up_top = TOP_WIDTH'(n_up >> 3);
          up_sel = SEL_DIV64;
        end
        SEL_DIV64: begin
          up_top = TOP_WIDTH'(n_up >> 2);
          up_sel = SEL_DIV256;
        end
        SEL_DIV256: begin
          up_top = TOP_WIDTH'(n_up >> 2);
          up_sel = SEL_DIV1024;
        end
        default: up_top = cfg.top_limit;
      endcase
    end
  end

  // period step down, dropping a prescaler once at the floor; at /1 it holds at top_floor
  always_comb begin
    if (wanted_sel_r == SEL_DIV1) begin
      dn_floor = cfg.top_floor;
    end else if (wanted_sel_r == SEL_DIV8 || wanted_sel_r == SEL_DIV64) begin
      dn_floor = cfg.top_limit >> 3;
    end else begin
      dn_floor = cfg.top_limit >> 2;
    end
    if (wanted_top_r > dn_floor) begin
      dn_top = wanted_top_r - 1'b1;
      dn_sel = wanted_sel_r;
    end else if (wanted_sel_r <= SEL_DIV1) begin
      dn_top = cfg.top_floor;
      dn_sel = SEL_DIV1;
    end else begin
      dn_top = cfg.top_limit;
      dn_sel = ((wanted_sel_r > SEL_DIV1024) ? SEL_DIV1024 : wanted_sel_r) - 1'b1;
    end
  end

  assign q_pop = q_valid && (!out_valid_r || out_tready);

  always_comb begin
    wanted_top_nxt = wanted_top_r;
    wanted_sel_nxt = wanted_sel_r;
    cur_top_nxt    = cur_top_r;
    cur_sel_nxt    = cur_sel_r;
    duty_a_nxt     = duty_a_r;
    duty_b_nxt     = duty_b_r;
    pending_nxt    = pending_r;
    duty_new       = duty_cur;
    if (q_pop) begin
      case (q_cmd.kind)
        KIND_PERIOD_NOW: begin
          wanted_top_nxt = q_cmd.map_top;
          wanted_sel_nxt = q_cmd.map_sel;
          cur_top_nxt    = q_cmd.map_top;
          cur_sel_nxt    = q_cmd.map_sel;
          duty_a_nxt     = clamp_a;
          duty_b_nxt     = clamp_b;
        end
        KIND_PERIOD_OVF: begin
          wanted_top_nxt = q_cmd.map_top;
          wanted_sel_nxt = q_cmd.map_sel;
          pending_nxt    = 1'b1;
        end
        KIND_PERIOD_UP: begin
          wanted_top_nxt = up_top;
          wanted_sel_nxt = up_sel;
          pending_nxt    = 1'b1;
        end
        KIND_PERIOD_DN: begin
          wanted_top_nxt = dn_top;
          wanted_sel_nxt = dn_sel;
          pending_nxt    = 1'b1;
        end
        KIND_DUTY_SET: duty_new = clamp_of(d_set, hi_cur, margin);
        KIND_DUTY_UP: begin
          if (duty_cur < hi_cur) duty_new = duty_cur + 1'b1;
        end
        KIND_DUTY_DN: begin
          if (duty_cur > margin) duty_new = duty_cur - 1'b1;
        end
        KIND_OVERFLOW: begin
          if (pending_r) begin
            cur_top_nxt = wanted_top_r;
            cur_sel_nxt = wanted_sel_r;
            duty_a_nxt  = clamp_a;
            duty_b_nxt  = clamp_b;
            pending_nxt = 1'b0;
          end
        end
        default: ;
      endcase
      if (q_cmd.kind == KIND_DUTY_SET || q_cmd.kind == KIND_DUTY_UP ||
          q_cmd.kind == KIND_DUTY_DN) begin
        if (q_cmd.channel) duty_b_nxt = duty_new;
        else               duty_a_nxt = duty_new;
      end
    end
  end

  always_comb begin
    if (q_pop)           out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
    else                 out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wanted_top_r <= TOP_LIMIT_RST;
      wanted_sel_r <= SEL_DIV1;
      cur_top_r    <= TOP_LIMIT_RST;
      cur_sel_r    <= SEL_DIV1;
      duty_a_r     <= TOP_WIDTH'(DUTY_MARGIN_RST);
      duty_b_r     <= TOP_WIDTH'(DUTY_MARGIN_RST);
      pending_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      wanted_top_r <= wanted_top_nxt;
      wanted_sel_r <= wanted_sel_nxt;
      cur_top_r    <= cur_top_nxt;
      cur_sel_r    <= cur_sel_nxt;
      duty_a_r     <= duty_a_nxt;
      duty_b_r     <= duty_b_nxt;
      pending_r    <= pending_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // state is frozen while a result waits, so it serves as the result register
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, pending_r, duty_b_r, duty_a_r, cur_sel_r, cur_top_r};

  a_cur_sel_legal: assert property (@(posedge clk) disable iff (!rst_n)
    cur_sel_r >= SEL_DIV1 && cur_sel_r <= SEL_DIV1024)
    else $error("prescaler in effect out of range");

  a_wanted_sel_legal: assert property (@(posedge clk) disable iff (!rst_n)
    wanted_sel_r >= SEL_DIV1 && wanted_sel_r <= SEL_DIV1024)
    else $error("pending prescaler out of range");

  a_ovf_clears: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop && q_cmd.kind == KIND_OVERFLOW |=> !pending_r)
    else $error("pending flag survived an overflow");

  a_deferred_sets: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop && (q_cmd.kind == KIND_PERIOD_OVF || q_cmd.kind == KIND_PERIOD_UP ||
              q_cmd.kind == KIND_PERIOD_DN) |=> pending_r)
    else $error("deferred period did not raise pending");

endmodule

FILE: sv/pwm_period_prescaler_duty_manager.sv
// pwm_period_prescaler_duty_manager: top level of the two-channel pwm period and duty manager
// an accepted beat passes through the queue into the back end's timer state, which holds its result beat
// throughput: one command per cycle while the receiver takes each result beat, set by the execute step in the back end
// the input side keeps taking beats while a result waits, until the two-entry queue fills
// reset: rst_n synchronous active low; registers, timer state and queue return to defaults
// depends on pwmpm_pkg, pwmpm_cfg, pwmpm_front, pwmpm_queue, pwmpm_back
module pwm_period_prescaler_duty_manager (
  input  logic        clk,
  input  logic        rst_n,
  // command stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [3:0]  in_tuser,    // [2:0] kind, [3] channel
  input  logic [31:0] in_tdata,    // [31:0] value
  // status stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,   // [15:0] active_top, [18:16] clock_select,
                                   // [34:19] compare_a, [50:35] compare_b,
                                   // [51] update_pending, [55:52] zero
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import pwmpm_pkg::*;

  cfg_t cfg;
  cmd_t push_cmd;
  cmd_t head_cmd;
  logic q_push;
  logic q_full;
  logic q_valid;
  logic q_pop;

  // register file: top_limit, top_floor, duty_margin
  pwmpm_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // front: take the beat, decode the kind and map the period to prescaler and top
  pwmpm_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .cfg       (cfg),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (push_cmd)
  );

  // queue decouples input stalls from output stalls
  pwmpm_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .head     (head_cmd)
  );

  // back: apply the command to the timer state and present the status beat
  pwmpm_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .q_valid    (q_valid),
    .q_cmd      (head_cmd),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

FILE: test/pwmpm_tb_pkg.sv
// pwmpm_tb_pkg: register map of the pwm manager as seen by the testbench modules
// depends on nothing; imported by the checker and by the testbench top
package pwmpm_tb_pkg;

  // byte addresses on the apb-style register port
  typedef enum logic [3:0] {
    REG_TOP_LIMIT   = 4'd0,
    REG_TOP_FLOOR   = 4'd4,
    REG_DUTY_MARGIN = 4'd8,
    REG_UNMAPPED    = 4'd12
  } reg_addr_t;

endpackage

FILE: test/pwmpm_checker.sv
// pwmpm_checker: watches the command, status and register channels of the pwm manager,
// predicts every status beat and compares it field by field
// depends on pwmpm_pkg and pwmpm_tb_pkg
module pwmpm_checker
  import pwmpm_pkg::*;
  import pwmpm_tb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [3:0]  in_tuser,
  input  logic [31:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [55:0] out_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  input  logic        drain_done,
  output int          fail_count,
  output int          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  // status beat, lowest field last so that it maps straight onto tdata
  typedef struct packed {
    logic                 update_pending;
    logic [TOP_WIDTH-1:0] compare_b;
    logic [TOP_WIDTH-1:0] compare_a;
    logic [SEL_WIDTH-1:0] clock_select;
    logic [TOP_WIDTH-1:0] active_top;
  } status_t;

  status_t status_q[$];

  // register copies
  logic [31:0] lim, flr, mrg;
  // timer state
  logic [31:0] want_top, want_sel, run_top, run_sel, cmp_a, cmp_b;
  logic        pend;
  bit          leftover_seen = 1'b0;

  initial begin
    fail_count = 0;
    outstanding = 0;
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t ns: %s", $time, what);
    fail_count++;
  endtask

  function automatic logic [31:0] duty_ceiling();
    return (run_top >= mrg) ? run_top - mrg : 32'd0;
  endfunction

  // lower bound first, upper bound last
  function automatic logic [31:0] clamp_duty(input logic [31:0] d);
    logic [31:0] hi;
    hi = duty_ceiling();
    if (d < mrg) d = mrg;
    if (d > hi) d = hi;
    return d & 32'h0000_FFFF;
  endfunction

  task automatic map_cycles(input logic [31:0] cycles);
    logic [31:0] c;
    logic [31:0] s;
    c = cycles;
    if (c <= lim) s = 32'(SEL_DIV1);
    else if ((c >> 3) <= lim) begin
      c = c >> 3;
      s = 32'(SEL_DIV8);
    end else if ((c >> 6) <= lim) begin
      c = c >> 6;
      s = 32'(SEL_DIV64);
    end else if ((c >> 8) <= lim) begin
      c = c >> 8;
      s = 32'(SEL_DIV256);
    end else begin
      c = c >> 10;
      s = 32'(SEL_DIV1024);
    end
    if (c > lim) c = lim;
    want_top = c & 32'h0000_FFFF;
    want_sel = s;
  endtask

  task automatic step_period_up();
    logic [31:0] n;
    n = want_top + 32'd1;
    if (n > lim) begin
      case (want_sel)
        SEL_DIV1: begin
          n = n >> 3;
          want_sel = 32'(SEL_DIV8);
        end
        SEL_DIV8: begin
          n = n >> 3;
          want_sel = 32'(SEL_DIV64);
        end
        SEL_DIV64: begin
          n = n >> 2;
          want_sel = 32'(SEL_DIV256);
        end
        SEL_DIV256: begin
          n = n >> 2;
          want_sel = 32'(SEL_DIV1024);
        end
        default: n = lim;
      endcase
    end
    want_top = n & 32'h0000_FFFF;
  endtask

  task automatic step_period_down();
    logic [31:0] fl;
    if (want_sel == SEL_DIV1) fl = flr;
    else if (want_sel == SEL_DIV8 || want_sel == SEL_DIV64) fl = lim >> 3;
    else fl = lim >> 2;
    if (want_top > fl) begin
      want_top = want_top - 32'd1;
    end else if (want_sel <= SEL_DIV1) begin
      want_top = flr;
      want_sel = 32'(SEL_DIV1);
    end else begin
      want_top = lim;
      want_sel = ((want_sel > SEL_DIV1024) ? 32'(SEL_DIV1024) : want_sel) - 32'd1;
    end
  endtask

  task automatic load_current();
    run_top = want_top;
    run_sel = want_sel;
    cmp_a = clamp_duty(cmp_a);
    cmp_b = clamp_duty(cmp_b);
  endtask

  task automatic execute(input kind_t k, input logic ch, input logic [31:0] v);
    logic [63:0] prod;
    logic [31:0] hi, d;
    d = ch ? cmp_b : cmp_a;
    case (k)
      KIND_PERIOD_NOW: begin
        map_cycles(v);
        load_current();
        d = ch ? cmp_b : cmp_a;
      end
      KIND_PERIOD_OVF: begin
        map_cycles(v);
        pend = 1'b1;
      end
      KIND_PERIOD_UP: begin
        step_period_up();
        pend = 1'b1;
      end
      KIND_PERIOD_DN: begin
        step_period_down();
        pend = 1'b1;
      end
      KIND_DUTY_SET: begin
        prod = ({32'd0, run_top} * {32'd0, v}) >> DUTY_FRAC;
        hi = duty_ceiling();
        d = (prod > {32'd0, hi}) ? hi : prod[31:0];
        d = clamp_duty(d);
      end
      KIND_DUTY_UP: begin
        if (d < duty_ceiling()) d = (d + 32'd1) & 32'h0000_FFFF;
      end
      KIND_DUTY_DN: begin
        if (d > mrg) d = d - 32'd1;
      end
      default: begin
        if (pend) begin
          load_current();
          pend = 1'b0;
          d = ch ? cmp_b : cmp_a;
        end
      end
    endcase
    if (ch) cmp_b = d;
    else cmp_a = d;
  endtask

  always @(posedge clk) begin : watch
    status_t got, want;
    if (!rst_n) begin
      lim = 32'(TOP_LIMIT_RST);
      flr = 32'(TOP_FLOOR_RST);
      mrg = 32'(DUTY_MARGIN_RST);
      want_top = 32'(TOP_LIMIT_RST);
      run_top = 32'(TOP_LIMIT_RST);
      want_sel = 32'(SEL_DIV1);
      run_sel = 32'(SEL_DIV1);
      cmp_a = 32'(DUTY_MARGIN_RST);
      cmp_b = 32'(DUTY_MARGIN_RST);
      pend = 1'b0;
      status_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr == REG_TOP_LIMIT) lim = pwdata & 32'h0000_FFFF;
        else if (paddr == REG_TOP_FLOOR) flr = pwdata & 32'h0000_FFFF;
        else if (paddr == REG_DUTY_MARGIN) mrg = pwdata & 32'h0000_7FFF;
      end
      // status first: a beat taken at this edge cannot answer itself
      if (out_tvalid && out_tready) begin
        got = status_t'(out_tdata[51:0]);
        if (status_q.size() == 0) begin
          report_mismatch("status beat with nothing expected");
        end else begin
          want = status_q.pop_front();
          if (got.active_top !== want.active_top)
            report_mismatch($sformatf("active_top %0d, expected %0d",
                                      got.active_top, want.active_top));
          if (got.clock_select !== want.clock_select)
            report_mismatch($sformatf("clock_select %0d, expected %0d",
                                      got.clock_select, want.clock_select));
          if (got.compare_a !== want.compare_a)
            report_mismatch($sformatf("compare_a %0d, expected %0d",
                                      got.compare_a, want.compare_a));
          if (got.compare_b !== want.compare_b)
            report_mismatch($sformatf("compare_b %0d, expected %0d",
                                      got.compare_b, want.compare_b));
          if (got.update_pending !== want.update_pending)
            report_mismatch($sformatf("update_pending %0b, expected %0b",
                                      got.update_pending, want.update_pending));
        end
      end
      if (in_tvalid && in_tready) begin
        execute(kind_t'(in_tuser[2:0]), in_tuser[3], in_tdata);
        want.active_top     = run_top[15:0];
        want.clock_select   = run_sel[2:0];
        want.compare_a      = cmp_a[15:0];
        want.compare_b      = cmp_b[15:0];
        want.update_pending = pend;
        status_q.push_back(want);
      end
      if (drain_done && !leftover_seen) begin
        leftover_seen = 1'b1;
        if (status_q.size() != 0)
          report_mismatch($sformatf("%0d status beats never arrived", status_q.size()));
      end
    end
    outstanding <= status_q.size();
  end

endmodule

FILE: test/testbench.sv
// testbench: drives commands and register writes into the pwm period and duty manager
// and gives the verdict; prediction and comparison live in pwmpm_checker
// depends on pwmpm_pkg, pwmpm_tb_pkg, pwmpm_checker and the block itself
module testbench
  import pwmpm_pkg::*;
  import pwmpm_tb_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLD_CYCLES = 400;   // long receiver hold-off
  localparam int STALL_LIMIT = 5000;  // cycles with no beat before giving up
  localparam int PHASE_ITEMS = 172;   // random commands per register setting

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [3:0]  in_tuser = '0;        // [2:0] kind, [3] channel
  logic [31:0] in_tdata = '0;        // [31:0] value
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;            // [15:0] active_top, [18:16] clock_select,
                                     // [34:19] compare_a, [50:35] compare_b,
                                     // [51] update_pending
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        drain_done = 1'b0;

  int          fail_count;
  int          outstanding;
  int          stall_cycles = 0;

  // idle_on and hold_req shared between the sender and the receiver; cur_limit used by the sender
  bit          idle_on = 1'b1;
  bit          hold_req = 1'b0;
  logic [31:0] cur_limit = 32'(TOP_LIMIT_RST);

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  pwm_period_prescaler_duty_manager DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  pwmpm_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tuser    (in_tuser),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .pready      (pready),
    .drain_done  (drain_done),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // watchdog: any beat on either channel restarts the count
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // receiver: random back-pressure, or one long hold-off when asked for
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        // counted here so the sender keeps offering beats meanwhile
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_tready <= !idle_on || ($urandom_range(99) >= 34);
      end
    end
  end

  // one command beat; returns at the edge that took it
  task automatic send_cmd(input kind_t k, input logic ch, input logic [31:0] v);
    while (idle_on && $urandom_range(99) < 34) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= {ch, k};
    in_tdata  <= v;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // setup cycle then access cycle, then a return to idle
  task automatic write_reg(input reg_addr_t a, input logic [31:0] d);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= a;
    pwdata  <= d;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // every command answers, so an empty expectation store means the block is idle
  task automatic wait_quiet();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic configure(input logic [31:0] lim, input logic [31:0] flr,
                           input logic [31:0] mrg);
    wait_quiet();
    write_reg(REG_TOP_LIMIT, lim);
    write_reg(REG_TOP_FLOOR, flr);
    write_reg(REG_DUTY_MARGIN, mrg);
    cur_limit = lim & 32'h0000_FFFF;
  endtask

  // periods clustered round the prescaler boundaries, plus wide values
  function automatic logic [31:0] pick_period();
    case ($urandom_range(6))
      0: return $urandom_range(cur_limit);
      1: return cur_limit + $urandom_range(16) - 8;
      2: return (cur_limit << 3) + $urandom_range(16) - 8;
      3: return (cur_limit << 6) + $urandom_range(16) - 8;
      4: return (cur_limit << 8) + $urandom_range(16) - 8;
      5: return (cur_limit << 10) + $urandom_range(2048) - 1024;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [31:0] pick_duty();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) return $urandom_range(65535);
    else if (r < 80) return (r < 75) ? 32'd0 : 32'd65535;
    else return $urandom();
  endfunction

  task automatic random_run(input int n, input bit with_holdoff);
    int          sent, r, len, i;
    bit          hold_asked;
    kind_t       k;
    logic        ch;
    logic [31:0] v;
    sent = 0;
    hold_asked = 1'b0;
    while (sent < n) begin
      if (with_holdoff && !hold_asked && sent >= n / 3) begin
        hold_asked = 1'b1;
        hold_req = 1'b1;
      end
      r  = $urandom_range(99);
      ch = 1'($urandom_range(1));
      if (r < 12) begin
        // runs of period steps so that prescaler boundaries get crossed
        k = $urandom_range(1) ? KIND_PERIOD_UP : KIND_PERIOD_DN;
        len = $urandom_range(40, 3);
        for (i = 0; i < len; i++) send_cmd(k, ch, $urandom());
        sent += len;
      end else if (r < 20) begin
        // runs of duty steps up to the bounds
        k = $urandom_range(1) ? KIND_DUTY_UP : KIND_DUTY_DN;
        len = $urandom_range(30, 2);
        for (i = 0; i < len; i++) send_cmd(k, ch, $urandom());
        sent += len;
      end else if (r < 35) begin
        send_cmd(KIND_OVERFLOW, ch, $urandom());
        sent++;
      end else begin
        k = kind_t'($urandom_range(7));
        case (k)
          KIND_PERIOD_NOW, KIND_PERIOD_OVF: v = pick_period();
          KIND_DUTY_SET:                    v = pick_duty();
          default:                          v = $urandom();
        endcase
        send_cmd(k, ch, v);
        sent++;
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part under the reset register values
    send_cmd(KIND_DUTY_SET,   1'b0, 32'd32768);
    send_cmd(KIND_DUTY_SET,   1'b1, 32'd65535);
    send_cmd(KIND_DUTY_SET,   1'b0, 32'hFFFF_FFFF);   // product beyond 16 bits
    send_cmd(KIND_DUTY_DN,    1'b0, 32'd0);
    send_cmd(KIND_DUTY_UP,    1'b1, 32'd0);           // already at the ceiling
    send_cmd(KIND_PERIOD_NOW, 1'b1, 32'd0);           // margin above top
    send_cmd(KIND_DUTY_DN,    1'b0, 32'hFFFF_FFFF);
    send_cmd(KIND_DUTY_UP,    1'b1, 32'd0);
    send_cmd(KIND_PERIOD_NOW, 1'b0, 32'd65535);
    send_cmd(KIND_PERIOD_NOW, 1'b0, 32'd65536);
    send_cmd(KIND_PERIOD_NOW, 1'b1, 32'd524287);
    send_cmd(KIND_PERIOD_NOW, 1'b0, 32'd4194304);
    send_cmd(KIND_PERIOD_NOW, 1'b0, 32'd67108863);
    send_cmd(KIND_PERIOD_NOW, 1'b1, 32'hFFFF_FFFF);   // period beyond range
    send_cmd(KIND_PERIOD_UP,  1'b0, 32'd0);           // saturates past /1024
    send_cmd(KIND_OVERFLOW,   1'b0, 32'd0);
    send_cmd(KIND_OVERFLOW,   1'b1, 32'hFFFF_FFFF);   // nothing pending
    send_cmd(KIND_PERIOD_OVF, 1'b0, 32'd1000);
    send_cmd(KIND_PERIOD_DN,  1'b0, 32'd0);
    send_cmd(KIND_DUTY_SET,   1'b1, 32'd0);
    send_cmd(KIND_OVERFLOW,   1'b0, 32'd0);
    send_cmd(KIND_PERIOD_NOW, 1'b0, 32'd3);           // at the floor
    send_cmd(KIND_PERIOD_DN,  1'b1, 32'd0);
    send_cmd(KIND_PERIOD_UP,  1'b0, 32'd0);
    send_cmd(KIND_OVERFLOW,   1'b1, 32'd0);

    // random part over several register settings, extremes among them
    configure(32'd65535, 32'd1, 32'd0);
    random_run(PHASE_ITEMS, 1'b1);                    // with the long hold-off

    configure(32'd3, 32'd65535, 32'd32767);
    random_run(PHASE_ITEMS, 1'b0);

    configure(32'd20, 32'd2, 32'd3);
    idle_on = 1'b0;                                   // stretch at full rate
    random_run(PHASE_ITEMS, 1'b0);
    idle_on = 1'b1;

    configure($urandom_range(65535, 3), $urandom_range(65535, 1), $urandom_range(32767));
    random_run(PHASE_ITEMS, 1'b0);

    configure(32'd3, 32'd1, 32'd0);
    write_reg(REG_UNMAPPED, $urandom());              // must change nothing
    random_run(PHASE_ITEMS, 1'b0);

    configure(32'd300, 32'd300, 32'd1);
    random_run(PHASE_ITEMS, 1'b0);

    // drain, then let the checker look for leftovers
    wait_quiet();
    drain_done <= 1'b1;
    repeat (2) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
